// ===== rtl/taj_pkg.sv =====
`timescale 1ns / 1ps

package taj_pkg;

	// Q30 angle constants, all positive and below 2^33.
	localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
	localparam logic [33:0] PI_Q30      = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;

	// Gain-corrected start value of the rotator x coordinate.
	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

	localparam int ATAN_ENTRIES = 24;
	localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128
	};

	// Width of the 2*pi quotient of a 16-bit angle at the coarsest scaling.
	localparam int QUO_W = 5;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_EULER_ORDER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRUST      = 8'd1;

	localparam logic signed [15:0] THRUST_RESET = -16'sd10045;

	typedef enum logic {
		ORDER_YXZ = 1'b0,
		ORDER_ZYX = 1'b1
	} euler_t;

	typedef logic signed [31:0] trig_t;
	typedef logic signed [33:0] ang_t;
	typedef logic signed [33:0] val_t;

	// Q30 by Q30 product, rounded half up back to Q30.
	function automatic trig_t mulq(trig_t a, trig_t b);
		logic signed [63:0] p;
		p = a * b + (64'sd1 <<< 29);
		return trig_t'(p >>> 30);
	endfunction

endpackage

// ===== rtl/taj_att_if.sv =====
`timescale 1ns / 1ps

interface taj_att_if ();
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
	modport monitor (input valid, ready, roll_angle, pitch_angle, yaw_angle);
endinterface

// ===== rtl/taj_jac_if.sv =====
`timescale 1ns / 1ps

interface taj_jac_if ();
	logic               valid;
	logic               ready;
	logic signed [15:0] north_per_pitch;
	logic signed [15:0] east_per_pitch;
	logic signed [15:0] down_per_pitch;
	logic signed [15:0] north_per_roll;
	logic signed [15:0] east_per_roll;
	logic signed [15:0] down_per_roll;
	logic signed [15:0] north_per_thrust;
	logic signed [15:0] east_per_thrust;
	logic signed [15:0] down_per_thrust;

	modport source (output valid, north_per_pitch, east_per_pitch, down_per_pitch,
		north_per_roll, east_per_roll, down_per_roll,
		north_per_thrust, east_per_thrust, down_per_thrust, input ready);
	modport sink (input valid, north_per_pitch, east_per_pitch, down_per_pitch,
		north_per_roll, east_per_roll, down_per_roll,
		north_per_thrust, east_per_thrust, down_per_thrust, output ready);
	modport monitor (input valid, ready, north_per_pitch, east_per_pitch, down_per_pitch,
		north_per_roll, east_per_roll, down_per_roll,
		north_per_thrust, east_per_thrust, down_per_thrust);
endinterface

// ===== rtl/taj_cfg_if.sv =====
`timescale 1ns / 1ps

interface taj_cfg_if import taj_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport monitor (input valid, ready, index, data);
endinterface

// ===== rtl/thrust_attitude_jacobian.sv =====
`timescale 1ns / 1ps

// Channel    Role    Moves per transaction
// attitude   sink    roll, pitch and yaw angle, signed Q2.13 radians
// jacobian   source  nine entries of the 3x3 effectiveness matrix, signed Q5.10
// cfg        sink    register index and write data (Euler order, thrust estimate)
//
// One attitude is taken per clock cycle while the skid register is empty. The
// depth is set by the rotator, one CORDIC iteration per stage, plus four angle
// reduction stages in front and six stages of fold undoing, products, sums,
// thrust scaling and rounding behind it.
// Reset (arst_n low) empties the pipeline and the output skid register and
// loads the registers with the YXZ form and a thrust estimate of -9.81.
// When a result waits, the pipeline still advances, moving it into the
// skid register, then holds as a whole until the result is taken; it moves
// again in the cycle after that transaction.
module thrust_attitude_jacobian import taj_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int OUT_FRAC_BITS   = 10,
	parameter int CORDIC_STAGES   = 16
) (
	input logic       clk,
	input logic       arst_n,
	taj_att_if.sink   attitude,
	taj_jac_if.source jacobian,
	taj_cfg_if.sink   cfg
);

	// Scaling of an input angle up to Q30, and the reciprocal of 2*pi at that
	// scaling with 32 extra fraction bits, used to estimate the turn count.
	localparam int SHIFT_IN = 30 - ANGLE_FRAC_BITS;
	localparam logic [63:0] RECIP_FULL = (64'd1 << (SHIFT_IN + 32)) / {30'd0, TWO_PI_Q30};
	localparam logic [23:0] RECIP = RECIP_FULL[23:0];

	localparam int COL2_SHIFT = 30 - OUT_FRAC_BITS;
	localparam int NST = CORDIC_STAGES + 10;

	localparam logic signed [49:0] HALF_T = 50'sd1 <<< 29;
	localparam logic signed [49:0] HALF_C = 50'sd1 <<< (COL2_SHIFT - 1);

	// Configuration registers, read directly by every stage. Writes must come only
	// while the block is idle; the block itself does not enforce it.
	euler_t             euler_order_q;
	logic signed [15:0] thrust_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euler_order_q <= ORDER_YXZ;
			thrust_q      <= THRUST_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_EULER_ORDER: euler_order_q <= euler_t'(cfg.data[0]);
				CFG_THRUST:      thrust_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// The pipeline moves as one unit. It holds only while the skid register
	// is occupied, which is a registered condition, so ready never depends
	// combinationally on the downstream ready.
	logic           en;
	logic [NST-1:0] vld_q;
	logic           skid_full_q;

	assign en = !skid_full_q;
	assign attitude.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], attitude.valid};
		end
	end

	// Stage 1: magnitude, sign, and an estimate of the whole turns in the
	// angle from a multiply by the reciprocal of 2*pi. The estimate is low
	// by at most one turn.
	logic signed [15:0] ang_in [3];
	logic [15:0]        mag_s1 [3];
	logic               neg_s1 [3];
	logic [QUO_W-1:0]   quo_s1 [3];

	assign ang_in[0] = attitude.roll_angle;
	assign ang_in[1] = attitude.pitch_angle;
	assign ang_in[2] = attitude.yaw_angle;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				logic [15:0] m;
				logic [39:0] p;
				m = ang_in[l][15] ? 16'(-ang_in[l]) : ang_in[l];
				p = 40'(m) * 40'(RECIP);
				mag_s1[l] <= m;
				neg_s1[l] <= ang_in[l][15];
				quo_s1[l] <= p[32+QUO_W-1:32];
			end
		end
	end

	// Stage 2: remainder of the Q30 magnitude after the estimated turns.
	logic [33:0] rem_s2 [3];
	logic        neg_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				logic [37:0] scaled;
				logic [37:0] turns;
				scaled = 38'(mag_s1[l]) << SHIFT_IN;
				turns  = 38'(38'(quo_s1[l]) * 38'(TWO_PI_Q30));
				rem_s2[l] <= 34'(scaled - turns);
				neg_s2[l] <= neg_s1[l];
			end
		end
	end

	// Stage 3: correct the turn estimate, wrap into [-pi, pi] and restore
	// the sign, matching a truncating remainder.
	ang_t ang_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				logic [33:0] r;
				ang_t        m;
				r = (rem_s2[l] >= TWO_PI_Q30) ? rem_s2[l] - TWO_PI_Q30 : rem_s2[l];
				m = (r > PI_Q30) ? ang_t'({1'b0, r[32:0]}) - ang_t'(TWO_PI_Q30)
					: ang_t'({1'b0, r[32:0]});
				ang_s3[l] <= neg_s2[l] ? -m : m;
			end
		end
	end

	// Stage 4: fold into [-pi/2, pi/2]; a folded angle has its sine and
	// cosine negated after the rotator.
	ang_t ang_s4  [3];
	logic flip_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (ang_s3[l] > ang_t'(HALF_PI_Q30)) begin
					ang_s4[l]  <= ang_s3[l] - ang_t'(PI_Q30);
					flip_s4[l] <= 1'b1;
				end else if (ang_s3[l] < -ang_t'(HALF_PI_Q30)) begin
					ang_s4[l]  <= ang_s3[l] + ang_t'(PI_Q30);
					flip_s4[l] <= 1'b1;
				end else begin
					ang_s4[l]  <= ang_s3[l];
					flip_s4[l] <= 1'b0;
				end
			end
		end
	end

	// Rotator: one CORDIC micro-rotation per stage for each of the three
	// angles side by side.
	trig_t rot_x_s    [CORDIC_STAGES][3];
	trig_t rot_y_s    [CORDIC_STAGES][3];
	ang_t  rot_z_s    [CORDIC_STAGES][3];
	logic  rot_flip_s [CORDIC_STAGES][3];
	trig_t rin_x      [CORDIC_STAGES][3];
	trig_t rin_y      [CORDIC_STAGES][3];
	ang_t  rin_z      [CORDIC_STAGES][3];
	logic  rin_flip   [CORDIC_STAGES][3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rin_x[0][l]    = CORDIC_GAIN_Q30;
			rin_y[0][l]    = '0;
			rin_z[0][l]    = ang_s4[l];
			rin_flip[0][l] = flip_s4[l];
			for (int i = 1; i < CORDIC_STAGES; i++) begin
				rin_x[i][l]    = rot_x_s[i-1][l];
				rin_y[i][l]    = rot_y_s[i-1][l];
				rin_z[i][l]    = rot_z_s[i-1][l];
				rin_flip[i][l] = rot_flip_s[i-1][l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				for (int l = 0; l < 3; l++) begin
					if (rin_z[i][l] >= 0) begin
						rot_x_s[i][l] <= rin_x[i][l] - (rin_y[i][l] >>> i);
						rot_y_s[i][l] <= rin_y[i][l] + (rin_x[i][l] >>> i);
						rot_z_s[i][l] <= rin_z[i][l] - ang_t'({4'b0, ATAN_Q30[i]});
					end else begin
						rot_x_s[i][l] <= rin_x[i][l] + (rin_y[i][l] >>> i);
						rot_y_s[i][l] <= rin_y[i][l] - (rin_x[i][l] >>> i);
						rot_z_s[i][l] <= rin_z[i][l] + ang_t'({4'b0, ATAN_Q30[i]});
					end
					rot_flip_s[i][l] <= rin_flip[i][l];
				end
			end
		end
	end

	// Stage 5: sine and cosine with the fold undone.
	trig_t sn_s5 [3];
	trig_t cs_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (rot_flip_s[CORDIC_STAGES-1][l]) begin
					sn_s5[l] <= -rot_y_s[CORDIC_STAGES-1][l];
					cs_s5[l] <= -rot_x_s[CORDIC_STAGES-1][l];
				end else begin
					sn_s5[l] <= rot_y_s[CORDIC_STAGES-1][l];
					cs_s5[l] <= rot_x_s[CORDIC_STAGES-1][l];
				end
			end
		end
	end

	// Stage 6: products of two trig terms. Lane 0 is roll (p), lane 1 pitch
	// (t), lane 2 yaw (y).
	trig_t ctcp_s6, stcp_s6, stsp_s6, ctsp_s6;
	trig_t cpcy_s6, cpsy_s6, spsy_s6, spcy_s6;
	trig_t cp_s6, sp_s6, ct_s6, st_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ctcp_s6 <= mulq(cs_s5[1], cs_s5[0]);
			stcp_s6 <= mulq(sn_s5[1], cs_s5[0]);
			stsp_s6 <= mulq(sn_s5[1], sn_s5[0]);
			ctsp_s6 <= mulq(cs_s5[1], sn_s5[0]);
			cpcy_s6 <= mulq(cs_s5[0], cs_s5[2]);
			cpsy_s6 <= mulq(cs_s5[0], sn_s5[2]);
			spsy_s6 <= mulq(sn_s5[0], sn_s5[2]);
			spcy_s6 <= mulq(sn_s5[0], cs_s5[2]);
			cp_s6   <= cs_s5[0];
			sp_s6   <= sn_s5[0];
			ct_s6   <= cs_s5[1];
			st_s6   <= sn_s5[1];
		end
	end

	// Stage 7: products of three trig terms for the ZYX form.
	trig_t cpcyct_s7, cpsyct_s7, spcyst_s7, spsyst_s7, cpcyst_s7, cpsyst_s7;
	trig_t ctcp_s7, stcp_s7, stsp_s7, ctsp_s7, cpcy_s7, cpsy_s7, spsy_s7, spcy_s7;
	trig_t cp_s7, sp_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			cpcyct_s7 <= mulq(cpcy_s6, ct_s6);
			cpsyct_s7 <= mulq(cpsy_s6, ct_s6);
			spcyst_s7 <= mulq(spcy_s6, st_s6);
			spsyst_s7 <= mulq(spsy_s6, st_s6);
			cpcyst_s7 <= mulq(cpcy_s6, st_s6);
			cpsyst_s7 <= mulq(cpsy_s6, st_s6);
			ctcp_s7   <= ctcp_s6;
			stcp_s7   <= stcp_s6;
			stsp_s7   <= stsp_s6;
			ctsp_s7   <= ctsp_s6;
			cpcy_s7   <= cpcy_s6;
			cpsy_s7   <= cpsy_s6;
			spsy_s7   <= spsy_s6;
			spcy_s7   <= spcy_s6;
			cp_s7     <= cp_s6;
			sp_s7     <= sp_s6;
		end
	end

	// Stage 8: the nine Q30 entries of the selected Euler form, in output
	// order: column 0 (pitch), column 1 (roll), column 2 (thrust).
	val_t v_d  [9];
	val_t v_s8 [9];

	always_comb begin
		case (euler_order_q)
			ORDER_YXZ: begin
				v_d[0] = val_t'(ctcp_s7);
				v_d[1] = '0;
				v_d[2] = -val_t'(stcp_s7);
				v_d[3] = -val_t'(stsp_s7);
				v_d[4] = -val_t'(cp_s7);
				v_d[5] = -val_t'(ctsp_s7);
				v_d[6] = val_t'(stcp_s7);
				v_d[7] = -val_t'(sp_s7);
				v_d[8] = val_t'(ctcp_s7);
			end
			ORDER_ZYX: begin
				v_d[0] = val_t'(cpcyct_s7);
				v_d[1] = val_t'(cpsyct_s7);
				v_d[2] = -val_t'(stcp_s7);
				v_d[3] = val_t'(cpsy_s7) - val_t'(spcyst_s7);
				v_d[4] = -val_t'(spsyst_s7) - val_t'(cpcy_s7);
				v_d[5] = -val_t'(ctsp_s7);
				v_d[6] = val_t'(spsy_s7) + val_t'(cpcyst_s7);
				v_d[7] = val_t'(cpsyst_s7) - val_t'(spcy_s7);
				v_d[8] = val_t'(ctcp_s7);
			end
			default: begin
				for (int j = 0; j < 9; j++) begin
					v_d[j] = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s8 <= v_d;
		end
	end

	// Stage 9: the angle columns are scaled by the thrust estimate; the
	// thrust column passes through at full width.
	logic signed [49:0] pr_s9 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				if (j < 6) begin
					pr_s9[j] <= v_s8[j] * thrust_q;
				end else begin
					pr_s9[j] <= 50'(v_s8[j]);
				end
			end
		end
	end

	// Stage 10: round half up to the output scaling and saturate.
	logic signed [15:0] res_d   [9];
	logic signed [15:0] res_s10 [9];

	always_comb begin
		for (int j = 0; j < 9; j++) begin
			logic signed [49:0] r;
			if (j < 6) begin
				r = (pr_s9[j] + HALF_T) >>> 30;
			end else begin
				r = (pr_s9[j] + HALF_C) >>> COL2_SHIFT;
			end
			if (r > 50'sd32767) begin
				res_d[j] = 16'sh7fff;
			end else if (r < -50'sd32768) begin
				res_d[j] = 16'sh8000;
			end else begin
				res_d[j] = r[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s10 <= res_d;
		end
	end

	// Output skid register. It catches the result in the last stage when the
	// sink does not take it, so the pipeline can still advance once more.
	logic signed [15:0] skid_q [9];
	logic signed [15:0] out_sel [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (jacobian.ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (vld_q[NST-1] && !jacobian.ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && vld_q[NST-1] && !jacobian.ready) begin
			skid_q <= res_s10;
		end
	end

	always_comb begin
		for (int j = 0; j < 9; j++) begin
			out_sel[j] = skid_full_q ? skid_q[j] : res_s10[j];
		end
	end

	assign jacobian.valid            = skid_full_q || vld_q[NST-1];
	assign jacobian.north_per_pitch  = out_sel[0];
	assign jacobian.east_per_pitch   = out_sel[1];
	assign jacobian.down_per_pitch   = out_sel[2];
	assign jacobian.north_per_roll   = out_sel[3];
	assign jacobian.east_per_roll    = out_sel[4];
	assign jacobian.down_per_roll    = out_sel[5];
	assign jacobian.north_per_thrust = out_sel[6];
	assign jacobian.east_per_thrust  = out_sel[7];
	assign jacobian.down_per_thrust  = out_sel[8];

`ifndef NO_ASSERTIONS
	// An accepted attitude occupies the first stage in the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		attitude.valid && attitude.ready |=> vld_q[0])
		else $error("accepted attitude did not enter the pipeline");

	// The skid register only fills from a valid result in the last stage.
	a_skid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(vld_q[NST-1]))
		else $error("skid register filled without a result");

	// While the skid register is held, no item moves in the pipeline.
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !jacobian.ready |=> $stable(vld_q))
		else $error("pipeline moved while the output was stalled");
`endif

endmodule

// ===== verif/taj_tb_if.sv =====
`timescale 1ns / 1ps

// The channels are the interfaces of the block itself; this file holds the
// common record type that the checker uses for one matrix.
package taj_tb_pkg;
	typedef struct packed {
		logic signed [15:0] npp, epp, dpp, npr, epr, dpr, npt, ept, dpt;
	} jac_t;
endpackage

// ===== verif/taj_jac_checker.sv =====
`timescale 1ns / 1ps

module taj_jac_checker import taj_pkg::*; import taj_tb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	taj_att_if.monitor att_mon,
	taj_jac_if.monitor jac_mon,
	taj_cfg_if.monitor cfg_mon,
	output int         errors,
	output int         pending
);
	localparam longint TWO_PI = 64'd6746518852;
	localparam longint PI_V = 64'd3373259426;
	localparam longint HALF_PI = 64'd1686629713;
	localparam longint ATAN [16] = '{843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
		524288, 262144, 131072, 65536, 32768};

	euler_t order_q;
	longint thrust_q;
	jac_t expected_q[$];

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return round_shift(a * b, 30);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic logic signed [15:0] scale_thrust(longint q);
		return clamp16(round_shift(q * thrust_q, 30));
	endfunction

	function automatic logic signed [15:0] dir_out(longint q);
		return clamp16(round_shift(q, 20));
	endfunction

	// Sine and cosine in Q30 by the same folded rotator as the block.
	function automatic void rotate(input logic signed [15:0] a, output longint s,
			output longint c);
		longint t, x, y, xn;
		bit flip;
		t = longint'(a) * (64'sd1 <<< 17);
		t = t % TWO_PI;
		x = 652032874;
		y = 0;
		flip = 0;
		if (t > PI_V) t -= TWO_PI;
		else if (t < -PI_V) t += TWO_PI;
		if (t > HALF_PI) begin
			t -= PI_V;
			flip = 1;
		end else if (t < -HALF_PI) begin
			t += PI_V;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (t >= 0) begin
				xn = x - (y >>> i);
				y = y + (x >>> i);
				t -= ATAN[i];
			end else begin
				xn = x + (y >>> i);
				y = y - (x >>> i);
				t += ATAN[i];
			end
			x = xn;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic jac_t predict_matrix(logic signed [15:0] ro, pi, ya);
		longint sp, cp, st, ct, sy, cy;
		jac_t m;
		rotate(ro, sp, cp);
		rotate(pi, st, ct);
		if (order_q == ORDER_YXZ) begin
			m.npp = scale_thrust(qmul(ct, cp));
			m.epp = '0;
			m.dpp = scale_thrust(-qmul(st, cp));
			m.npr = scale_thrust(-qmul(st, sp));
			m.epr = scale_thrust(-cp);
			m.dpr = scale_thrust(-qmul(ct, sp));
			m.npt = dir_out(qmul(st, cp));
			m.ept = dir_out(-sp);
			m.dpt = dir_out(qmul(ct, cp));
		end else begin
			rotate(ya, sy, cy);
			m.npp = scale_thrust(qmul(qmul(cp, cy), ct));
			m.epp = scale_thrust(qmul(qmul(cp, sy), ct));
			m.dpp = scale_thrust(-qmul(st, cp));
			m.npr = scale_thrust(qmul(cp, sy) - qmul(qmul(sp, cy), st));
			m.epr = scale_thrust(-qmul(qmul(sp, sy), st) - qmul(cy, cp));
			m.dpr = scale_thrust(-qmul(ct, sp));
			m.npt = dir_out(qmul(sp, sy) + qmul(qmul(cp, cy), st));
			m.ept = dir_out(qmul(qmul(cp, sy), st) - qmul(cy, sp));
			m.dpt = dir_out(qmul(cp, ct));
		end
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		jac_t got, want;
		int bad;
		if (!arst_n) begin
			order_q <= ORDER_YXZ;
			thrust_q = -10045;
			errors <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			bad = 0;
			// Results are checked before the attitude of this edge is queued.
			if (jac_mon.valid && jac_mon.ready) begin
				got = {jac_mon.north_per_pitch, jac_mon.east_per_pitch,
					jac_mon.down_per_pitch, jac_mon.north_per_roll, jac_mon.east_per_roll,
					jac_mon.down_per_roll, jac_mon.north_per_thrust,
					jac_mon.east_per_thrust, jac_mon.down_per_thrust};
				if (expected_q.size() == 0) begin
					$display("%0t: matrix with none expected, actual %h", $time, got);
					bad = 1;
				end else begin
					want = expected_q.pop_front();
					for (int k = 8; k >= 0; k--)
						if (got[k*16 +: 16] !== want[k*16 +: 16]) begin
							$display("%0t: entry %0d expected %0d actual %0d", $time, 8 - k,
								$signed(want[k*16 +: 16]), $signed(got[k*16 +: 16]));
							bad = bad + 1;
						end
				end
			end
			if (att_mon.valid && att_mon.ready)
				expected_q.push_back(predict_matrix(att_mon.roll_angle,
					att_mon.pitch_angle, att_mon.yaw_angle));
			if (cfg_mon.valid && cfg_mon.ready) begin
				if (cfg_mon.index == CFG_EULER_ORDER) order_q <= euler_t'(cfg_mon.data[0]);
				else if (cfg_mon.index == CFG_THRUST) thrust_q = longint'($signed(cfg_mon.data));
			end
			if (bad != 0)
				errors <= errors + bad;
			pending <= expected_q.size();
		end
	end
endmodule

// ===== verif/thrust_attitude_jacobian_tb.sv =====
`timescale 1ns / 1ps

module thrust_attitude_jacobian_tb import taj_pkg::*; ();

	// An index outside the register list, which the block ignores.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 8'd7;

	logic clk = 0;
	logic arst_n = 0;
	int errors, pending;
	int idle_cycles = 0;
	bit hold_off = 0;

	taj_att_if attitude ();
	taj_jac_if jacobian ();
	taj_cfg_if cfg ();

	thrust_attitude_jacobian dut (.clk, .arst_n, .attitude, .jacobian, .cfg);

	taj_jac_checker jac_check (.clk, .arst_n, .att_mon(attitude), .jac_mon(jacobian),
		.cfg_mon(cfg), .errors, .pending);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Half the time no gap, otherwise mostly short gaps and now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		attitude.valid = 0;
		attitude.roll_angle = 0;
		attitude.pitch_angle = 0;
		attitude.yaw_angle = 0;
		jacobian.ready = 0;
		cfg.valid = 0;
		cfg.index = CFG_EULER_ORDER;
		cfg.data = 0;
	end

	// The receiver stalls at random, plus one long hold-off so that the
	// pipeline fills and pushes back on the attitude channel.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				jacobian.ready <= 0;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			g = gap_len();
			jacobian.ready <= (g == 0);
			@(posedge clk);
			repeat (g) @(posedge clk);
			jacobian.ready <= 1;
			@(posedge clk);
		end
	end

	// Watchdog: a long stretch with no transaction on any channel ends the run.
	always @(posedge clk) begin
		if ((attitude.valid && attitude.ready) || (jacobian.valid && jacobian.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
	endtask

	// One attitude transaction; the valid stays high into the next one unless a gap is drawn.
	task automatic send_attitude(input logic [15:0] r, p, y);
		int g;
		g = gap_len();
		if (g != 0) begin
			attitude.valid <= 0;
			repeat (g) @(posedge clk);
		end
		attitude.valid <= 1;
		attitude.roll_angle <= r;
		attitude.pitch_angle <= p;
		attitude.yaw_angle <= y;
		do @(posedge clk); while (!attitude.ready);
	endtask

	// Waits until every matrix has arrived, then past the pipeline depth.
	task automatic drain();
		attitude.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_attitudes(input int n);
		logic [15:0] r, p, y;
		for (int i = 0; i < n; i++) begin
			r = 16'($urandom);
			p = 16'($urandom);
			y = 16'($urandom);
			// Most roll and pitch angles stay within half a turn so that the sweep is even.
			if ($urandom_range(0, 3) != 0) begin
				r = 16'($signed(r) % 25736);
				p = 16'($signed(p) % 25736);
			end
			send_attitude(r, p, y);
		end
	endtask

	logic [15:0] corner [8] = '{16'h0000, 16'h7fff, 16'h8000, 16'd12868,
		-16'sd12868, 16'd25736, 16'd6434, 16'hffff};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset settings first: YXZ form, default thrust, with yaw that must not matter.
		for (int i = 0; i < 8; i++)
			send_attitude(corner[i], corner[7 - i], corner[(i + 3) % 8]);
		random_attitudes(150);
		drain();

		// ZYX form at the most negative thrust; the extremes saturate.
		write_reg(CFG_EULER_ORDER, 16'hfffd);
		write_reg(CFG_THRUST, 16'h8000);
		for (int i = 0; i < 8; i++)
			send_attitude(corner[i], corner[(i + 2) % 8], corner[7 - i]);
		hold_off = 1;
		random_attitudes(350);
		drain();

		// An index beyond the register list is ignored by the block.
		write_reg(CFG_IDX_UNMAPPED, 16'h1234);
		write_reg(CFG_THRUST, 16'h7fff);
		random_attitudes(250);
		drain();

		write_reg(CFG_EULER_ORDER, 16'h0000);
		write_reg(CFG_THRUST, 16'h0000);
		random_attitudes(100);
		drain();

		write_reg(CFG_THRUST, 16'($urandom));
		random_attitudes(200);
		drain();

		write_reg(CFG_EULER_ORDER, 16'h0001);
		write_reg(CFG_THRUST, -16'sd10045);
		random_attitudes(200);
		drain();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/taj_pkg.sv
rtl/taj_att_if.sv
rtl/taj_jac_if.sv
rtl/taj_cfg_if.sv
rtl/thrust_attitude_jacobian.sv
verif/taj_tb_if.sv
verif/taj_jac_checker.sv
verif/thrust_attitude_jacobian_tb.sv
